// ===== design/onc_pkg.sv =====
package onc_pkg;

   // lane count: three divide / square root lanes, shared by encode and decode
   localparam int LANES = 3;

   // divider: quotient bits, divisor bits, dividend bits
   localparam int QW = 33;
   localparam int DW = 32;
   localparam int NW = QW + DW;

   // square root: root bits and trial width
   localparam int RW = 17;
   localparam int TW = QW + 2;

   // squared component width (|n| <= 32768)
   localparam int SQW = 31;

   // payload widths of the stream groups
   localparam int REQ_W = 80;
   localparam int RSP_W = 80;

   // Q1.15 constants
   localparam logic [15:0] HALF_Q15 = 16'd16384;
   localparam logic [15:0] ONE_Q15  = 16'd32768;
   localparam logic [15:0] MAX_Q15  = 16'd32767;

   // item modes
   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   // control and sideband that travel with each item
   typedef struct packed {
      logic             mode;
      logic             zero;
      logic [LANES-1:0] neg;
      logic [15:0]      enc_u;
      logic [15:0]      enc_v;
   } side_type;

   typedef logic [LANES-1:0][NW-1:0] num_type;
   typedef logic [LANES-1:0][DW-1:0] den_type;
   typedef logic [LANES-1:0][QW-1:0] quo_type;
   typedef logic [LANES-1:0][RW-1:0] root_type;

endpackage

// ===== design/onc_front.sv =====
module onc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  logic               mode,
   input  logic [15:0]        vec_x,
   input  logic [15:0]        vec_y,
   input  logic [15:0]        vec_z,
   input  logic [15:0]        enc_u,
   input  logic [15:0]        enc_v,
   output logic               out_valid,
   output onc_pkg::side_type  out_side,
   output onc_pkg::num_type   out_num,
   output onc_pkg::den_type   out_den
);

   // stage A: norms, folding, decode unfold
   logic [15:0]        ax, ay, az;
   logic [16:0]        len_in;
   logic [17:0]        two_len;
   logic [17:0]        au_in, av_in;
   logic [15:0]        uc, vc;
   logic signed [17:0] fx, fy, afx, afy, nz, t;
   logic signed [17:0] n_in [onc_pkg::LANES];

   logic               a_valid_ff, a_mode_ff, a_zero_ff;
   logic [16:0]        a_len_ff;
   logic [17:0]        a_au_ff, a_av_ff;
   logic signed [17:0] a_n_ff [onc_pkg::LANES];

   always_comb begin
      ax = vec_x[15] ? (~vec_x + 16'd1) : vec_x;
      ay = vec_y[15] ? (~vec_y + 16'd1) : vec_y;
      az = vec_z[15] ? (~vec_z + 16'd1) : vec_z;
      len_in  = {1'b0, ax} + {1'b0, ay} + {1'b0, az};
      two_len = {len_in, 1'b0};
      // fold over the octahedron when z is negative
      if (vec_z[15]) begin
         au_in = vec_x[15] ? {2'b00, ay} : (two_len - {2'b00, ay});
         av_in = vec_y[15] ? {2'b00, ax} : (two_len - {2'b00, ax});
      end else begin
         au_in = {1'b0, len_in} + {{2{vec_x[15]}}, vec_x};
         av_in = {1'b0, len_in} + {{2{vec_y[15]}}, vec_y};
      end
      // decode: clamp, map to [-1,1], unfold
      uc  = (enc_u > onc_pkg::ONE_Q15) ? onc_pkg::ONE_Q15 : enc_u;
      vc  = (enc_v > onc_pkg::ONE_Q15) ? onc_pkg::ONE_Q15 : enc_v;
      fx  = $signed({1'b0, uc, 1'b0}) - 18'sd32768;
      fy  = $signed({1'b0, vc, 1'b0}) - 18'sd32768;
      afx = (fx < 0) ? -fx : fx;
      afy = (fy < 0) ? -fy : fy;
      nz  = 18'sd32768 - afx - afy;
      t   = (nz < 0) ? -nz : 18'sd0;
      n_in[0] = (fx >= 0) ? (fx - t) : (fx + t);
      n_in[1] = (fy >= 0) ? (fy - t) : (fy + t);
      n_in[2] = nz;
   end

   // stage B: squares for decode, encode dividends
   logic [15:0]              m [onc_pkg::LANES];
   logic [onc_pkg::SQW-1:0]  sq_in [onc_pkg::LANES];
   logic [onc_pkg::LANES-1:0] neg_in;
   logic [32:0]              enum_u_in, enum_v_in;

   logic                     b_valid_ff, b_mode_ff, b_zero_ff;
   logic [onc_pkg::LANES-1:0] b_neg_ff;
   logic [onc_pkg::SQW-1:0]  b_sq_ff [onc_pkg::LANES];
   logic [32:0]              b_enum_u_ff, b_enum_v_ff;
   logic [17:0]              b_den_ff;

   always_comb begin
      for (int l = 0; l < onc_pkg::LANES; l++) begin
         neg_in[l] = a_n_ff[l][17];
         m[l]      = a_n_ff[l][17] ? 16'(-a_n_ff[l]) : a_n_ff[l][15:0];
         sq_in[l]  = onc_pkg::SQW'(32'(m[l]) * 32'(m[l]));
      end
      enum_u_in = {a_au_ff, 15'd0} + 33'(a_len_ff);
      enum_v_in = {a_av_ff, 15'd0} + 33'(a_len_ff);
   end

   // stage C: sum of squares, lane dividends and divisors
   logic [onc_pkg::DW-1:0] s_in;
   onc_pkg::side_type      side_in;
   onc_pkg::num_type       num_in;
   onc_pkg::den_type       den_in;

   logic                   c_valid_ff;
   onc_pkg::side_type      c_side_ff;
   onc_pkg::num_type       c_num_ff;
   onc_pkg::den_type       c_den_ff;

   always_comb begin
      s_in = onc_pkg::DW'(b_sq_ff[0]) + onc_pkg::DW'(b_sq_ff[1]) + onc_pkg::DW'(b_sq_ff[2]);
      side_in.mode  = b_mode_ff;
      side_in.zero  = b_zero_ff;
      side_in.neg   = b_neg_ff;
      side_in.enc_u = '0;
      side_in.enc_v = '0;
      if (b_mode_ff == onc_pkg::MODE_DECODE) begin
         for (int l = 0; l < onc_pkg::LANES; l++) begin
            num_in[l] = onc_pkg::NW'({b_sq_ff[l], 32'd0});
            den_in[l] = s_in;
         end
      end else begin
         num_in[0] = onc_pkg::NW'(b_enum_u_ff);
         num_in[1] = onc_pkg::NW'(b_enum_v_ff);
         num_in[2] = '0;
         den_in[0] = onc_pkg::DW'({b_den_ff, 1'b0}) >> 1;
         den_in[1] = onc_pkg::DW'(b_den_ff);
         den_in[2] = onc_pkg::DW'(1);
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   // payload, advance with the pipe
   always_ff @(posedge clock) begin
      if (adv) begin
         a_mode_ff   <= mode;
         a_zero_ff   <= (mode == onc_pkg::MODE_ENCODE) && (len_in == 17'd0);
         a_len_ff    <= len_in;
         a_au_ff     <= au_in;
         a_av_ff     <= av_in;
         a_n_ff      <= n_in;
         b_mode_ff   <= a_mode_ff;
         b_zero_ff   <= a_zero_ff;
         b_neg_ff    <= neg_in;
         b_sq_ff     <= sq_in;
         b_enum_u_ff <= enum_u_in;
         b_enum_v_ff <= enum_v_in;
         b_den_ff    <= {a_len_ff, 1'b0};
         c_side_ff   <= side_in;
         c_num_ff    <= num_in;
         c_den_ff    <= den_in;
      end
   end

   assign out_valid = c_valid_ff;
   assign out_side  = c_side_ff;
   assign out_num   = c_num_ff;
   assign out_den   = c_den_ff;

endmodule

// ===== design/onc_div.sv =====
module onc_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  onc_pkg::side_type in_side,
   input  onc_pkg::num_type  in_num,
   input  onc_pkg::den_type  in_den,
   output logic              out_valid,
   output onc_pkg::side_type out_side,
   output onc_pkg::quo_type  out_quo
);

   // one restoring step per stage, three lanes side by side
   logic [onc_pkg::QW-1:0]   v_ff;
   onc_pkg::side_type        side_ff [onc_pkg::QW];
   onc_pkg::den_type         r_ff    [onc_pkg::QW-1];
   onc_pkg::den_type         d_ff    [onc_pkg::QW-1];
   onc_pkg::quo_type         q_ff    [onc_pkg::QW];

   onc_pkg::den_type         src_r [onc_pkg::QW];
   onc_pkg::den_type         src_d [onc_pkg::QW];
   onc_pkg::quo_type         src_q [onc_pkg::QW];
   onc_pkg::den_type         r_in  [onc_pkg::QW-1];
   onc_pkg::quo_type         q_in  [onc_pkg::QW];

   always_comb begin
      logic [onc_pkg::DW:0] trial;
      logic [onc_pkg::DW:0] diff;
      logic                 take;
      for (int l = 0; l < onc_pkg::LANES; l++) begin
         src_r[0][l] = in_num[l][onc_pkg::NW-1:onc_pkg::QW];
         src_q[0][l] = in_num[l][onc_pkg::QW-1:0];
         src_d[0][l] = in_den[l];
      end
      for (int k = 1; k < onc_pkg::QW; k++) begin
         src_r[k] = r_ff[k-1];
         src_d[k] = d_ff[k-1];
         src_q[k] = q_ff[k-1];
      end
      for (int k = 0; k < onc_pkg::QW; k++) begin
         for (int l = 0; l < onc_pkg::LANES; l++) begin
            trial = {src_r[k][l], src_q[k][l][onc_pkg::QW-1]};
            diff  = trial - {1'b0, src_d[k][l]};
            take  = (trial >= {1'b0, src_d[k][l]});
            q_in[k][l] = {src_q[k][l][onc_pkg::QW-2:0], take};
            if (k < onc_pkg::QW - 1) begin
               r_in[k][l] = take ? diff[onc_pkg::DW-1:0] : trial[onc_pkg::DW-1:0];
            end
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[onc_pkg::QW-2:0], in_valid};
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= in_side;
         for (int k = 1; k < onc_pkg::QW; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
         for (int k = 0; k < onc_pkg::QW - 1; k++) begin
            r_ff[k] <= r_in[k];
            d_ff[k] <= src_d[k];
         end
         q_ff <= q_in;
      end
   end

   assign out_valid = v_ff[onc_pkg::QW-1];
   assign out_side  = side_ff[onc_pkg::QW-1];
   assign out_quo   = q_ff[onc_pkg::QW-1];

endmodule

// ===== design/onc_sqrt.sv =====
module onc_sqrt (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  onc_pkg::side_type in_side,
   input  onc_pkg::quo_type  in_quo,
   output logic              out_valid,
   output onc_pkg::side_type out_side,
   output onc_pkg::root_type out_root
);

   // one root bit per stage, most significant first
   logic [onc_pkg::RW-1:0] v_ff;
   onc_pkg::side_type      side_ff [onc_pkg::RW];
   onc_pkg::quo_type       rem_ff  [onc_pkg::RW-1];
   onc_pkg::root_type      root_ff [onc_pkg::RW];

   onc_pkg::side_type      side_in;
   onc_pkg::quo_type       src_rem  [onc_pkg::RW];
   onc_pkg::root_type      src_root [onc_pkg::RW];
   onc_pkg::quo_type       rem_in   [onc_pkg::RW-1];
   onc_pkg::root_type      root_in  [onc_pkg::RW];

   always_comb begin
      logic [onc_pkg::TW-1:0] tv;
      logic                   take;
      // encode results leave the divider here; keep them with the item
      side_in = in_side;
      if (in_side.mode == onc_pkg::MODE_ENCODE) begin
         side_in.enc_u = in_quo[0][15:0];
         side_in.enc_v = in_quo[1][15:0];
      end
      src_rem[0]  = in_quo;
      src_root[0] = '0;
      for (int k = 1; k < onc_pkg::RW; k++) begin
         src_rem[k]  = rem_ff[k-1];
         src_root[k] = root_ff[k-1];
      end
      for (int k = 0; k < onc_pkg::RW; k++) begin
         for (int l = 0; l < onc_pkg::LANES; l++) begin
            tv   = (onc_pkg::TW'(src_root[k][l]) << (onc_pkg::RW - k))
                 + (onc_pkg::TW'(1) << (2 * (onc_pkg::RW - 1 - k)));
            take = (onc_pkg::TW'(src_rem[k][l]) >= tv);
            root_in[k][l] = src_root[k][l]
                          | (take ? (onc_pkg::RW'(1) << (onc_pkg::RW - 1 - k)) : '0);
            if (k < onc_pkg::RW - 1) begin
               rem_in[k][l] = take ? onc_pkg::QW'(onc_pkg::TW'(src_rem[k][l]) - tv)
                                   : src_rem[k][l];
            end
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[onc_pkg::RW-2:0], in_valid};
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_in;
         for (int k = 1; k < onc_pkg::RW; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign out_valid = v_ff[onc_pkg::RW-1];
   assign out_side  = side_ff[onc_pkg::RW-1];
   assign out_root  = root_ff[onc_pkg::RW-1];

endmodule

// ===== design/octahedral_normal_codec.sv =====
// Octahedral normal codec. Each transaction either encodes a signed Q1.15 direction
// into an unsigned Q1.15 (u,v) pair (tuser low) or decodes a (u,v) pair into a
// saturated signed Q1.15 unit vector (tuser high); results are rounded to
// nearest. One transaction is taken every cycle unless the result side stalls;
// the pipe is three front stages, a 33-stage restoring divider (one quotient bit per
// stage, three lanes), a 17-stage square root (one root bit per stage) and the
// output register. A stall on the result side freezes the whole pipe.
module octahedral_normal_codec (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // vec_x[15:0], vec_y[31:16], vec_z[47:32], enc_u[63:48], enc_v[79:64]
   input  logic [onc_pkg::REQ_W-1:0] req_tdata,
   // mode
   input  logic                      req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // out_u[15:0], out_v[31:16], unit_x[47:32], unit_y[63:48], unit_z[79:64]
   output logic [onc_pkg::RSP_W-1:0] rsp_tdata,
   // zero_vector
   output logic                      rsp_tuser
);

   logic              adv;
   logic              f_valid, d_valid, s_valid;
   onc_pkg::side_type f_side, d_side, s_side;
   onc_pkg::num_type  f_num;
   onc_pkg::den_type  f_den;
   onc_pkg::quo_type  d_quo;
   onc_pkg::root_type s_root;

   // advance whenever the output register is free or being drained
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   onc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid),
      .mode      (req_tuser),
      .vec_x     (req_tdata[15:0]),
      .vec_y     (req_tdata[31:16]),
      .vec_z     (req_tdata[47:32]),
      .enc_u     (req_tdata[63:48]),
      .enc_v     (req_tdata[79:64]),
      .out_valid (f_valid),
      .out_side  (f_side),
      .out_num   (f_num),
      .out_den   (f_den)
   );

   onc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (f_valid),
      .in_side   (f_side),
      .in_num    (f_num),
      .in_den    (f_den),
      .out_valid (d_valid),
      .out_side  (d_side),
      .out_quo   (d_quo)
   );

   onc_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (d_valid),
      .in_side   (d_side),
      .in_quo    (d_quo),
      .out_valid (s_valid),
      .out_side  (s_side),
      .out_root  (s_root)
   );

   // round root to a Q1.15 component, apply sign, saturate
   logic [15:0] unit_in [onc_pkg::LANES];
   logic [15:0] out_u_in, out_v_in;

   always_comb begin
      logic [onc_pkg::RW:0]   inc;
      logic [onc_pkg::RW-1:0] c;
      logic [onc_pkg::RW-1:0] negc;
      for (int l = 0; l < onc_pkg::LANES; l++) begin
         inc  = {1'b0, s_root[l]} + (onc_pkg::RW+1)'(1);
         c    = inc[onc_pkg::RW:1];
         negc = ~c + onc_pkg::RW'(1);
         if (s_side.mode == onc_pkg::MODE_ENCODE) begin
            unit_in[l] = '0;
         end else if (s_side.neg[l]) begin
            unit_in[l] = negc[15:0];
         end else if (c > onc_pkg::RW'(onc_pkg::MAX_Q15)) begin
            unit_in[l] = onc_pkg::MAX_Q15;
         end else begin
            unit_in[l] = c[15:0];
         end
      end
      if (s_side.mode == onc_pkg::MODE_DECODE) begin
         out_u_in = '0;
         out_v_in = '0;
      end else if (s_side.zero) begin
         out_u_in = onc_pkg::HALF_Q15;
         out_v_in = onc_pkg::HALF_Q15;
      end else begin
         out_u_in = s_side.enc_u;
         out_v_in = s_side.enc_v;
      end
   end

   // output register
   logic                      rsp_valid_ff;
   logic [onc_pkg::RSP_W-1:0] rsp_data_ff;
   logic                      rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= {unit_in[2], unit_in[1], unit_in[0], out_v_in, out_u_in};
         rsp_user_ff <= (s_side.mode == onc_pkg::MODE_ENCODE) && s_side.zero;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== design/onc_checker.sv =====
module onc_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic [onc_pkg::REQ_W-1:0] req_tdata,
   input logic                      req_tuser,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [onc_pkg::RSP_W-1:0] rsp_tdata,
   input logic                      rsp_tuser
);

   logic req_seen;
   assign req_seen = req_tvalid && (req_tdata != '0 || req_tuser || !req_tuser);

   // a stalled result holds its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // an empty output stage never blocks new transactions
   assert property (@(posedge clock) disable iff (reset)
      req_seen && !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   // a zero direction encodes to the center with no unit vector
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[15:0] == onc_pkg::HALF_Q15
         && rsp_tdata[31:16] == onc_pkg::HALF_Q15 && rsp_tdata[79:32] == '0)
      else $error("zero flag with wrong payload");

   // encoded coordinates never exceed one
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:0] <= onc_pkg::ONE_Q15
         && rsp_tdata[31:16] <= onc_pkg::ONE_Q15)
      else $error("encoded coordinate above one");

endmodule

bind octahedral_normal_codec onc_checker u_onc_checker (.*);
